FILE: hdl/ctmd_pkg.sv
package ctmd_pkg;

  // field widths of one transfer
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int ELAPSED_W = 16;
  localparam int STATUS_W  = 2;

  // internal widths
  localparam int YADJ_W = 15;   // year shifted up by one era, March based
  localparam int ERA_W  = 6;    // era index plus one, 0..41
  localparam int YOE_W  = 9;    // year of era, 0..399
  localparam int DOY_W  = 9;    // day of March based year plus day of month
  localparam int TOD_W  = 11;   // minutes into the day
  localparam int DOE_W  = 18;   // day of era
  localparam int DAYS_W = 23;   // day count from the start of era minus one
  localparam int MIN_W  = 34;   // minute count
  localparam int DIFF_W = MIN_W + 1;

  // conversion stages, without the clamp stage
  localparam int CONV_STAGES = 5;

  // arithmetic constants
  localparam int YEARS_PER_ERA = 400;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int MIN_PER_DAY   = 1440;
  localparam int MIN_PER_HOUR  = 60;
  localparam int DAYS_PER_YEAR = 365;
  // floor(x / 25) for x < 1049 as (x * 5243) >> 17
  localparam int RECIP_25_ERA  = 5243;
  localparam int RECIP_25_ERA_SH = 17;
  // floor(x / 25) for x < 100 as (x * 41) >> 10
  localparam int RECIP_25_YOE  = 41;
  localparam int RECIP_25_YOE_SH = 10;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_EXACT = 2'd0,
    STATUS_NEG   = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  // first day of each month in the March based year, by raw month code
  function automatic logic [DOY_W-1:0] doy_base(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] res;
    case (month)
      4'd0:    res = 9'd275;
      4'd1:    res = 9'd306;
      4'd2:    res = 9'd337;
      4'd3:    res = 9'd0;
      4'd4:    res = 9'd31;
      4'd5:    res = 9'd61;
      4'd6:    res = 9'd92;
      4'd7:    res = 9'd122;
      4'd8:    res = 9'd153;
      4'd9:    res = 9'd184;
      4'd10:   res = 9'd214;
      4'd11:   res = 9'd245;
      4'd12:   res = 9'd275;
      4'd13:   res = 9'd306;
      4'd14:   res = 9'd337;
      default: res = 9'd367;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/ctmd_conv.sv
module ctmd_conv (
  input  logic                           clk,
  input  logic [ctmd_pkg::YEAR_W-1:0]    year,
  input  logic [ctmd_pkg::MONTH_W-1:0]   month,
  input  logic [ctmd_pkg::DAY_W-1:0]     day,
  input  logic [ctmd_pkg::HOUR_W-1:0]    hour,
  input  logic [ctmd_pkg::MINUTE_W-1:0]  minute,
  output logic [ctmd_pkg::MIN_W-1:0]     minutes
);
  import ctmd_pkg::*;

  localparam int RQ_W = (YADJ_W - 4) + 13;
  localparam int CQ_W = 13;

  // stage 1: March based year, era, day within year, time of day
  logic [YADJ_W-1:0] yadj;
  logic [RQ_W-1:0]   rq;
  logic [YADJ_W-1:0] yadj_s1_r;
  logic [ERA_W-1:0]  era_s1_r;
  logic [DOY_W-1:0]  dd_s1_r;
  logic [TOD_W-1:0]  tod_s1_r;

  assign yadj = YADJ_W'(year) + YADJ_W'(YEARS_PER_ERA)
              - ((month <= MONTH_W'(2)) ? YADJ_W'(1) : YADJ_W'(0));
  assign rq   = RQ_W'(yadj[YADJ_W-1:4]) * RQ_W'(RECIP_25_ERA);

  always_ff @(posedge clk) begin
    yadj_s1_r <= yadj;
    era_s1_r  <= rq[RECIP_25_ERA_SH +: ERA_W];
    dd_s1_r   <= doy_base(month) + DOY_W'(day);
    tod_s1_r  <= TOD_W'(hour) * TOD_W'(MIN_PER_HOUR) + TOD_W'(minute);
  end

  // stage 2: year of era and days of whole eras
  logic [YADJ_W-1:0] yrem;
  logic [YOE_W-1:0]  yoe_s2_r;
  logic [DAYS_W-1:0] era_days_s2_r;
  logic [DOY_W-1:0]  dd_s2_r;
  logic [TOD_W-1:0]  tod_s2_r;

  assign yrem = yadj_s1_r - YADJ_W'(era_s1_r) * YADJ_W'(YEARS_PER_ERA);

  always_ff @(posedge clk) begin
    yoe_s2_r      <= yrem[YOE_W-1:0];
    era_days_s2_r <= DAYS_W'(era_s1_r) * DAYS_W'(DAYS_PER_ERA);
    dd_s2_r       <= dd_s1_r;
    tod_s2_r      <= tod_s1_r;
  end

  // stage 3: day of era with leap day corrections
  logic [YOE_W-3:0]  quad;
  logic [CQ_W-1:0]   cq;
  logic [1:0]        cent;
  logic [DOE_W-1:0]  doe_s3_r;
  logic [DAYS_W-1:0] era_days_s3_r;
  logic [TOD_W-1:0]  tod_s3_r;

  assign quad = yoe_s2_r[YOE_W-1:2];
  assign cq   = CQ_W'(quad) * CQ_W'(RECIP_25_YOE);
  assign cent = cq[RECIP_25_YOE_SH +: 2];

  always_ff @(posedge clk) begin
    doe_s3_r      <= DOE_W'(yoe_s2_r) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(quad)
                   - DOE_W'(cent) + DOE_W'(dd_s2_r);
    era_days_s3_r <= era_days_s2_r;
    tod_s3_r      <= tod_s2_r;
  end

  // stage 4: day count
  logic [DAYS_W-1:0] days_s4_r;
  logic [TOD_W-1:0]  tod_s4_r;

  always_ff @(posedge clk) begin
    days_s4_r <= era_days_s3_r + DAYS_W'(doe_s3_r);
    tod_s4_r  <= tod_s3_r;
  end

  // stage 5: minute count
  logic [MIN_W-1:0] minutes_s5_r;

  always_ff @(posedge clk) begin
    minutes_s5_r <= MIN_W'(days_s4_r) * MIN_W'(MIN_PER_DAY) + MIN_W'(tod_s4_r);
  end

  assign minutes = minutes_s5_r;

endmodule

FILE: hdl/ctmd_clamp.sv
module ctmd_clamp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld,
  input  logic [ctmd_pkg::MIN_W-1:0]      start_minutes,
  input  logic [ctmd_pkg::MIN_W-1:0]      end_minutes,
  output logic                            out_vld,
  output logic [ctmd_pkg::ELAPSED_W-1:0]  elapsed,
  output ctmd_pkg::status_t               status
);
  import ctmd_pkg::*;

  logic [DIFF_W-1:0]    diff;
  logic                 neg;
  logic                 sat;
  logic                 vld_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  status_t              status_r;
  status_t              status_nxt;

  // signed difference, sign bit and overflow above 16 bits
  assign diff = DIFF_W'(end_minutes) - DIFF_W'(start_minutes);
  assign neg  = diff[DIFF_W-1];
  assign sat  = !neg && (|diff[DIFF_W-2:ELAPSED_W]);

  always_comb begin
    if (neg) begin
      elapsed_nxt = '0;
      status_nxt  = STATUS_NEG;
    end else if (sat) begin
      elapsed_nxt = '1;
      status_nxt  = STATUS_SAT;
    end else begin
      elapsed_nxt = diff[ELAPSED_W-1:0];
      status_nxt  = STATUS_EXACT;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    status_r  <= status_nxt;
  end

  assign out_vld = vld_r;
  assign elapsed = elapsed_r;
  assign status  = status_r;

endmodule

FILE: hdl/civil_timestamp_minute_difference.sv
// channel   ports                         transfer
// input     start, busy, in_*             start high and busy low at a rising edge
// result    out_valid, out_*              out_valid high for one cycle, always taken
//
// one transfer is accepted every cycle; busy is held low
// each result passes five conversion stages per timestamp, then one subtract and clamp stage
// the two timestamps are converted side by side in two copies of the converter
// synchronous reset clears the valid bits only; data registers are not reset
// the receiver cannot stall, so the pipeline advances on every clock
module civil_timestamp_minute_difference (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ctmd_pkg::YEAR_W-1:0]     in_start_year,
  input  logic [ctmd_pkg::MONTH_W-1:0]    in_start_month,
  input  logic [ctmd_pkg::DAY_W-1:0]      in_start_day,
  input  logic [ctmd_pkg::HOUR_W-1:0]     in_start_hour,
  input  logic [ctmd_pkg::MINUTE_W-1:0]   in_start_minute,
  input  logic [ctmd_pkg::YEAR_W-1:0]     in_end_year,
  input  logic [ctmd_pkg::MONTH_W-1:0]    in_end_month,
  input  logic [ctmd_pkg::DAY_W-1:0]      in_end_day,
  input  logic [ctmd_pkg::HOUR_W-1:0]     in_end_hour,
  input  logic [ctmd_pkg::MINUTE_W-1:0]   in_end_minute,
  output logic                            out_valid,
  output logic [ctmd_pkg::ELAPSED_W-1:0]  out_elapsed_minutes,
  output logic [ctmd_pkg::STATUS_W-1:0]   out_status
);
  import ctmd_pkg::*;

  logic                   in_xfer;
  logic [CONV_STAGES-1:0] vld_r;
  logic [CONV_STAGES-1:0] vld_nxt;
  logic [MIN_W-1:0]       start_minutes;
  logic [MIN_W-1:0]       end_minutes;
  status_t                status;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // valid bits alongside the conversion stages
  assign vld_nxt = {vld_r[CONV_STAGES-2:0], in_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // start and end timestamps to minute counts
  ctmd_conv u_conv_start (
    .clk     (clk),
    .year    (in_start_year),
    .month   (in_start_month),
    .day     (in_start_day),
    .hour    (in_start_hour),
    .minute  (in_start_minute),
    .minutes (start_minutes)
  );

  ctmd_conv u_conv_end (
    .clk     (clk),
    .year    (in_end_year),
    .month   (in_end_month),
    .day     (in_end_day),
    .hour    (in_end_hour),
    .minute  (in_end_minute),
    .minutes (end_minutes)
  );

  // difference with clamp and saturation
  ctmd_clamp u_clamp (
    .clk           (clk),
    .rst_n         (rst_n),
    .vld           (vld_r[CONV_STAGES-1]),
    .start_minutes (start_minutes),
    .end_minutes   (end_minutes),
    .out_vld       (out_valid),
    .elapsed       (out_elapsed_minutes),
    .status        (status)
  );

  assign out_status = STATUS_W'(status);

endmodule

FILE: hdl/ctmd_checker.sv
module ctmd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [ctmd_pkg::ELAPSED_W-1:0]  out_elapsed_minutes,
  input logic [ctmd_pkg::STATUS_W-1:0]   out_status
);
  import ctmd_pkg::*;

  // the block takes a transfer every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // every result follows an accepted transfer through the conversion and clamp stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without matching input transfer");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_EXACT || out_status == STATUS_NEG
                   || out_status == STATUS_SAT))
    else $error("undefined status code");

  // negative difference reads zero
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_NEG) |-> out_elapsed_minutes == '0)
    else $error("clamped result not zero");

  // saturated difference reads all ones
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_SAT) |-> out_elapsed_minutes == '1)
    else $error("saturated result not at maximum");

endmodule

bind civil_timestamp_minute_difference ctmd_checker u_ctmd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_elapsed_minutes (out_elapsed_minutes),
  .out_status          (out_status)
);

FILE: test/tb_civil_timestamp_minute_difference.sv
module tb_civil_timestamp_minute_difference;
  import ctmd_pkg::*;

  localparam int      STALL_LIMIT  = 1000;
  localparam int      DRAIN_CYCLES = 12;
  localparam int      IDLE_PCT     = 19;
  localparam longint  EPOCH_DAYS   = 719468;   // days from era origin to 1970-01-01
  localparam longint  SAT_MINUTES  = (1 << ELAPSED_W) - 1;
  localparam int      JANUARY      = 1;
  localparam int      FEBRUARY     = 2;
  localparam int      MARCH        = 3;
  localparam int      DECEMBER     = 12;

  typedef struct {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } stamp_t;

  typedef struct {
    int                   id;
    logic [ELAPSED_W-1:0] minutes;
    status_t              status;
  } elapsed_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [YEAR_W-1:0]     in_start_year = '0;
  logic [MONTH_W-1:0]    in_start_month = '0;
  logic [DAY_W-1:0]      in_start_day = '0;
  logic [HOUR_W-1:0]     in_start_hour = '0;
  logic [MINUTE_W-1:0]   in_start_minute = '0;
  logic [YEAR_W-1:0]     in_end_year = '0;
  logic [MONTH_W-1:0]    in_end_month = '0;
  logic [DAY_W-1:0]      in_end_day = '0;
  logic [HOUR_W-1:0]     in_end_hour = '0;
  logic [MINUTE_W-1:0]   in_end_minute = '0;
  logic                  out_valid;
  logic [ELAPSED_W-1:0]  out_elapsed_minutes;
  logic [STATUS_W-1:0]   out_status;

  elapsed_t pending_elapsed[$];
  elapsed_t oldest;
  int       error_count = 0;
  int       sent_count = 0;
  int       stall_cycles = 0;
  bit       gaps_on = 1'b1;

  civil_timestamp_minute_difference uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_start_year       (in_start_year),
    .in_start_month      (in_start_month),
    .in_start_day        (in_start_day),
    .in_start_hour       (in_start_hour),
    .in_start_minute     (in_start_minute),
    .in_end_year         (in_end_year),
    .in_end_month        (in_end_month),
    .in_end_day          (in_end_day),
    .in_end_hour         (in_end_hour),
    .in_end_minute       (in_end_minute),
    .out_valid           (out_valid),
    .out_elapsed_minutes (out_elapsed_minutes),
    .out_status          (out_status)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // minutes since 1970-01-01 00:00, march based years, floor division into eras
  function automatic longint epoch_minutes(stamp_t t);
    longint y, m, d, era, yoe, doy, doe;
    y = longint'(t.year);
    m = longint'(t.month);
    d = longint'(t.day);
    if (m <= FEBRUARY) y = y - 1;
    era = (y >= 0 ? y : y - (YEARS_PER_ERA - 1)) / YEARS_PER_ERA;
    yoe = y - era * YEARS_PER_ERA;
    doy = (153 * (m + (m >= MARCH ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
    return (era * DAYS_PER_ERA + doe - EPOCH_DAYS) * MIN_PER_DAY
           + longint'(t.hour) * MIN_PER_HOUR + longint'(t.minute);
  endfunction

  // end minus start, clamped at zero and saturated at the top of the field
  function automatic elapsed_t minute_difference(stamp_t s, stamp_t e);
    elapsed_t r;
    longint   diff;
    diff = epoch_minutes(e) - epoch_minutes(s);
    r.id = sent_count;
    if (diff < 0) begin
      r.minutes = '0;
      r.status  = STATUS_NEG;
    end else if (diff > SAT_MINUTES) begin
      r.minutes = '1;
      r.status  = STATUS_SAT;
    end else begin
      r.minutes = ELAPSED_W'(diff);
      r.status  = STATUS_EXACT;
    end
    return r;
  endfunction

  function automatic stamp_t ts(int y, int mo, int d, int h, int mi);
    stamp_t t;
    t.year   = YEAR_W'(y);
    t.month  = MONTH_W'(mo);
    t.day    = DAY_W'(d);
    t.hour   = HOUR_W'(h);
    t.minute = MINUTE_W'(mi);
    return t;
  endfunction

  // mostly calendar values, now and then any bit pattern of the field
  function automatic stamp_t random_stamp();
    stamp_t t;
    t.year   = ($urandom_range(99) < 15) ? YEAR_W'($urandom) : YEAR_W'($urandom_range(9999));
    t.month  = ($urandom_range(99) < 15) ? MONTH_W'($urandom) : MONTH_W'($urandom_range(12, 1));
    t.day    = ($urandom_range(99) < 15) ? DAY_W'($urandom) : DAY_W'($urandom_range(31, 1));
    t.hour   = ($urandom_range(99) < 15) ? HOUR_W'($urandom) : HOUR_W'($urandom_range(23));
    t.minute = ($urandom_range(99) < 15) ? MINUTE_W'($urandom) : MINUTE_W'($urandom_range(59));
    return t;
  endfunction

  // two timestamps in the same day, the same month or adjacent months, so most differences stay exact
  task automatic make_close_pair(output stamp_t s, output stamp_t e);
    stamp_t t;
    s = random_stamp();
    e = random_stamp();
    case ($urandom_range(3))
      0: begin
        e.year  = s.year;
        e.month = s.month;
        e.day   = s.day;
      end
      1: begin
        e.year  = s.year;
        e.month = s.month;
      end
      2: begin
        e.year  = s.year;
        e.month = s.month + 1'b1;
      end
      default: begin
        // across new year
        if (s.year == '1) s.year = s.year - 1'b1;
        s.month = MONTH_W'(DECEMBER);
        e.year  = s.year + 1'b1;
        e.month = MONTH_W'(JANUARY);
      end
    endcase
    if ($urandom_range(99) < 30) begin
      t = s;
      s = e;
      e = t;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // one transfer on the input channel, with optional idle cycles ahead of it
  task automatic send_pair(input stamp_t s, input stamp_t e);
    elapsed_t want;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_start_year   <= s.year;
    in_start_month  <= s.month;
    in_start_day    <= s.day;
    in_start_hour   <= s.hour;
    in_start_minute <= s.minute;
    in_end_year     <= e.year;
    in_end_month    <= e.month;
    in_end_day      <= e.day;
    in_end_hour     <= e.hour;
    in_end_minute   <= e.minute;
    start           <= 1'b1;
    want = minute_difference(s, e);
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    pending_elapsed = {pending_elapsed, want};
    sent_count++;
    @(posedge clk);
  endtask

  // field extremes, clamp boundaries, leap rules and odd field values
  task automatic test_directed_cases();
    send_pair(ts(1970, 1, 1, 0, 0), ts(1970, 1, 1, 0, 0));
    send_pair(ts(1970, 1, 1, 0, 0), ts(1970, 1, 1, 0, 1));
    send_pair(ts(1970, 1, 1, 0, 1), ts(1970, 1, 1, 0, 0));
    send_pair(ts(2024, 1, 1, 0, 0), ts(2024, 2, 15, 18, 15));
    send_pair(ts(2024, 1, 1, 0, 0), ts(2024, 2, 15, 18, 16));
    send_pair(ts(0, 0, 0, 0, 0), ts(16383, 15, 31, 31, 63));
    send_pair(ts(16383, 15, 31, 31, 63), ts(0, 0, 0, 0, 0));
    send_pair(ts(16383, 15, 31, 31, 63), ts(16383, 15, 31, 31, 63));
    send_pair(ts(2000, 2, 28, 12, 0), ts(2000, 3, 1, 12, 0));
    send_pair(ts(1900, 2, 28, 12, 0), ts(1900, 3, 1, 12, 0));
    send_pair(ts(1999, 12, 31, 23, 59), ts(2000, 1, 1, 0, 0));
    // year zero january and february fall in the era before
    send_pair(ts(0, 2, 28, 0, 0), ts(0, 3, 1, 0, 0));
    send_pair(ts(0, 1, 1, 0, 0), ts(0, 1, 2, 0, 0));
    send_pair(ts(0, 1, 1, 0, 0), ts(0, 2, 1, 0, 0));
    // month zero and months above twelve
    send_pair(ts(2023, 0, 1, 0, 0), ts(2023, 1, 1, 0, 0));
    send_pair(ts(2023, 12, 1, 0, 0), ts(2023, 13, 1, 0, 0));
    send_pair(ts(2023, 13, 1, 0, 0), ts(2023, 14, 1, 0, 0));
    send_pair(ts(2023, 14, 1, 0, 0), ts(2023, 15, 1, 0, 0));
    // day zero, hour and minute beyond their nominal range
    send_pair(ts(2023, 6, 0, 0, 0), ts(2023, 6, 1, 0, 0));
    send_pair(ts(2023, 6, 10, 0, 0), ts(2023, 6, 10, 31, 63));
    send_pair(ts(16383, 2, 28, 0, 0), ts(16383, 3, 1, 0, 0));
    send_pair(ts(9999, 12, 31, 23, 59), ts(9999, 12, 31, 0, 0));
  endtask

  // close pairs with random content plus unrelated timestamps, with idle gaps
  task automatic test_random_pairs();
    stamp_t s, e;
    repeat (500) begin
      if ($urandom_range(99) < 70) begin
        make_close_pair(s, e);
      end else begin
        s = random_stamp();
        e = random_stamp();
      end
      send_pair(s, e);
    end
  endtask

  // a long burst with a transfer on every cycle
  task automatic test_back_to_back();
    stamp_t s, e;
    gaps_on = 1'b0;
    repeat (230) begin
      make_close_pair(s, e);
      send_pair(s, e);
    end
    gaps_on = 1'b1;
  endtask

  // result check against the oldest outstanding difference
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_elapsed.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          oldest = pending_elapsed.pop_front();
          if (out_elapsed_minutes !== oldest.minutes)
            report_mismatch($sformatf("item %0d elapsed %0d, expected %0d",
                                      oldest.id, out_elapsed_minutes, oldest.minutes));
          if (out_status !== oldest.status)
            report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                      oldest.id, out_status, oldest.status));
        end
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid unknown");
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_civil_timestamp_minute_difference: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_pairs();
    test_back_to_back();
    start <= 1'b0;
    while (pending_elapsed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_civil_timestamp_minute_difference: PASS");
    end else begin
      $display("tb_civil_timestamp_minute_difference: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ctmd_pkg.sv
hdl/ctmd_conv.sv
hdl/ctmd_clamp.sv
hdl/civil_timestamp_minute_difference.sv
hdl/ctmd_checker.sv
test/tb_civil_timestamp_minute_difference.sv
